@@ src/vfv_pkg.sv @@
// Shared constants and types for the voxel face visibility block.
`timescale 1ns / 1ps

package vfv_pkg;

  // Interior chunk size and stored kind width.
  localparam int SIZE_X    = 16;
  localparam int SIZE_Y    = 16;
  localparam int SIZE_Z    = 16;
  localparam int KIND_BITS = 8;

  // The store holds the chunk plus a one-voxel halo on every side.
  localparam int PAD_X  = SIZE_X + 2;
  localparam int PAD_Y  = SIZE_Y + 2;
  localparam int PAD_Z  = SIZE_Z + 2;
  localparam int PLANE  = PAD_X * PAD_Y;
  localparam int DEPTH  = PLANE * PAD_Z;
  localparam int ADDR_W = $clog2(DEPTH);

  // Result field widths.
  localparam int TRI_W = 16;
  localparam int VTX_W = 17;
  localparam int VIS_W = 13;

  // Item operations.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Register indexes.
  localparam int REG_CHUNK     = 0;
  localparam int REG_NEIGHBOUR = 1;

  // One cycle of requests to the voxel store.
  typedef struct packed {
    logic                 we;
    logic [ADDR_W-1:0]    waddr;
    logic [KIND_BITS-1:0] wdata;
    logic                 re;
    logic [ADDR_W-1:0]    raddr;
  } vfv_ram_req_t;

endpackage

@@ src/vfv_voxel_ram.sv @@
// Voxel kind store: one write port and one read port with registered read data.
`timescale 1ns / 1ps

module vfv_voxel_ram import vfv_pkg::*; (
  input  logic                 clk_i,
  input  vfv_ram_req_t         req_i,
  output logic [KIND_BITS-1:0] rdata_o
);

  logic [KIND_BITS-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_o <= mem_q[req_i.raddr];
    end
  end

endmodule

@@ src/voxel_face_visibility.sv @@
// Voxel face visibility: top level with item sequencer, totals and register port.
//
// Items enter on the s_axis channel. A write item (tuser = 0) stores a voxel
// kind at a padded coordinate and produces no result. A query item (tuser = 1)
// names an interior voxel; one result leaves on the m_axis channel with the
// visible face mask, the voxel's triangle and vertex counts, the running scan
// totals and the hole flag. m_axis_tuser marks a query outside the interior.
// The APB port holds chunk_loaded (address 0) and neighbour_loaded (address 4);
// write them only while no item is in flight.
// One item is handled at a time. A write goes from acceptance through an address
// step and a store write back to acceptance. A query reads the centre voxel and
// its six neighbours one after another through the single read port of the
// voxel store, then forms its result. A query outside the interior skips the
// reads and goes straight to its result.
// The result sits in an output register, so the next item is accepted while
// it waits; a query finishing while the register is still occupied waits
// until the receiver takes the earlier result.
// After reset the store is cleared one voxel per cycle, all 5832 voxels at the
// default chunk size, and s_axis_tready stays low until that pass is done.
`timescale 1ns / 1ps

module voxel_face_visibility import vfv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [4:0] pos_x, [9:5] pos_y, [14:10] pos_z, [22:15] voxel_kind, [23] scan_start
  input  logic [23:0] s_axis_tdata,
  // [0] op
  input  logic        s_axis_tuser,
  // Results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [5:0] face_mask, [6] visible, [10:7] voxel_triangles, [15:11] voxel_vertices,
  // [31:16] total_triangles, [48:32] total_vertices, [61:49] visible_count,
  // [62] hole_seen, [63] zero
  output logic [63:0] m_axis_tdata,
  // [0] bad_coord
  output logic        m_axis_tuser,
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_CALC  = 3'd2;
  localparam logic [2:0] ST_WRITE = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;
  localparam logic [2:0] ST_LAST  = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  // Read steps: the centre, then the neighbours in face mask order.
  localparam logic [2:0] STEP_CENTRE = 3'd0;
  localparam logic [2:0] STEP_POS_Y  = 3'd1;
  localparam logic [2:0] STEP_NEG_Y  = 3'd2;
  localparam logic [2:0] STEP_POS_Z  = 3'd3;
  localparam logic [2:0] STEP_NEG_Z  = 3'd4;
  localparam logic [2:0] STEP_NEG_X  = 3'd5;
  localparam logic [2:0] STEP_POS_X  = 3'd6;

  localparam logic [TRI_W-1:0] TRI_MAX = '1;
  localparam logic [VTX_W-1:0] VTX_MAX = '1;
  localparam logic [VIS_W-1:0] VIS_MAX = '1;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [4:0] x, input logic [4:0] y,
                                                  input logic [4:0] z);
    logic [31:0] lin;
    lin = 32'(x) + 32'(PAD_X) * (32'(y) + 32'(PAD_Y) * 32'(z));
    return lin[ADDR_W-1:0];
  endfunction

  logic [2:0]           state_q, state_d;
  logic [ADDR_W-1:0]    clr_q;
  logic [2:0]           step_q;
  logic                 rd_pend_q;
  logic [2:0]           rd_step_q;

  logic                 op_q;
  logic [4:0]           x_q, y_q, z_q;
  logic [7:0]           kind_q;
  logic                 start_q;
  logic [ADDR_W-1:0]    addr_q;
  logic                 wr_ok_q;
  logic                 bad_q;
  logic                 solid_q;
  logic [5:0]           empty_q;

  logic                 chunk_q;
  logic [5:0]           nl_q;

  logic [TRI_W-1:0]     tri_sum_q;
  logic [VTX_W-1:0]     vtx_sum_q;
  logic [VIS_W-1:0]     vis_sum_q;
  logic                 hole_q;

  logic                 m_valid_q;
  logic [63:0]          m_data_q;
  logic                 m_user_q;

  vfv_ram_req_t         ram_req;
  logic [KIND_BITS-1:0] ram_rdata;
  logic [ADDR_W-1:0]    rd_addr;

  logic                 in_xfer;
  logic                 out_load;
  logic                 cfg_wr;

  vfv_voxel_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == ST_DONE) && (!m_valid_q || m_axis_tready);

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == 1'(REG_NEIGHBOUR)) ? {26'd0, nl_q} : {31'd0, chunk_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_q <= 1'b0;
      nl_q    <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == 1'(REG_CHUNK)) begin
        chunk_q <= pwdata[0];
      end else begin
        nl_q <= pwdata[5:0];
      end
    end
  end

  // ---------------------------------------------------------------- store access
  always_comb begin
    case (step_q)
      STEP_CENTRE: rd_addr = addr_q;
      STEP_POS_Y:  rd_addr = addr_q + ADDR_W'(PAD_X);
      STEP_NEG_Y:  rd_addr = addr_q - ADDR_W'(PAD_X);
      STEP_POS_Z:  rd_addr = addr_q + ADDR_W'(PLANE);
      STEP_NEG_Z:  rd_addr = addr_q - ADDR_W'(PLANE);
      STEP_NEG_X:  rd_addr = addr_q - ADDR_W'(1);
      STEP_POS_X:  rd_addr = addr_q + ADDR_W'(1);
      default:     rd_addr = addr_q;
    endcase
  end

  always_comb begin
    ram_req       = '0;
    ram_req.raddr = rd_addr;
    case (state_q)
      ST_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = clr_q;
      end
      ST_WRITE: begin
        ram_req.we    = wr_ok_q;
        ram_req.waddr = addr_q;
        ram_req.wdata = KIND_BITS'(kind_q);
      end
      ST_READ: begin
        ram_req.re = 1'b1;
      end
      default: begin
        ram_req.we = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_q == ADDR_W'(DEPTH - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (in_xfer) state_d = ST_CALC;
      ST_CALC: begin
        if (op_q == OP_WRITE) begin
          state_d = ST_WRITE;
        end else if (x_q == 5'd0 || 32'(x_q) > SIZE_X || y_q == 5'd0 || 32'(y_q) > SIZE_Y ||
                     z_q == 5'd0 || 32'(z_q) > SIZE_Z) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_READ;
        end
      end
      ST_WRITE: state_d = ST_IDLE;
      ST_READ:  if (step_q == STEP_POS_X) state_d = ST_LAST;
      ST_LAST:  state_d = ST_DONE;
      ST_DONE:  if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      step_q    <= STEP_CENTRE;
      rd_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_pend_q <= ram_req.re;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + ADDR_W'(1);
      end
      if (state_q == ST_READ) begin
        step_q <= (step_q == STEP_POS_X) ? STEP_CENTRE : step_q + 3'd1;
      end
    end
  end

  // Item fields, address and the read results.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q    <= s_axis_tuser;
      x_q     <= s_axis_tdata[4:0];
      y_q     <= s_axis_tdata[9:5];
      z_q     <= s_axis_tdata[14:10];
      kind_q  <= s_axis_tdata[22:15];
      start_q <= s_axis_tdata[23];
    end
    if (state_q == ST_CALC) begin
      addr_q  <= cell_addr(x_q, y_q, z_q);
      wr_ok_q <= (32'(x_q) < PAD_X) && (32'(y_q) < PAD_Y) && (32'(z_q) < PAD_Z);
      bad_q   <= (state_d == ST_DONE);
    end
    rd_step_q <= step_q;
    if (rd_pend_q) begin
      if (rd_step_q == STEP_CENTRE) begin
        solid_q <= (ram_rdata != '0);
      end else begin
        for (int j = 0; j < 6; j++) begin
          if (rd_step_q == 3'(j + 1)) empty_q[j] <= (ram_rdata == '0);
        end
      end
    end
  end

  // ---------------------------------------------------------------- result
  logic [5:0]       halo, side_ok, miss, mask;
  logic [2:0]       faces;
  logic [3:0]       tri_add;
  logic [4:0]       vtx_add;
  logic             vis, hole_new;
  logic [TRI_W-1:0] tri_base, tri_new;
  logic [VTX_W-1:0] vtx_base, vtx_new;
  logic [VIS_W-1:0] vis_base, vis_new;
  logic [TRI_W:0]   tri_ext;
  logic [VTX_W:0]   vtx_ext;
  logic [VIS_W:0]   vis_ext;

  always_comb begin
    // A neighbour lies in the halo exactly when the centre sits on that face of the chunk.
    halo[0] = (32'(y_q) == SIZE_Y);
    halo[1] = (y_q == 5'd1);
    halo[2] = (32'(z_q) == SIZE_Z);
    halo[3] = (z_q == 5'd1);
    halo[4] = (x_q == 5'd1);
    halo[5] = (32'(x_q) == SIZE_X);
    side_ok = {nl_q[1], nl_q[0], nl_q[4], nl_q[5], nl_q[2], nl_q[3]};
    miss    = {6{!chunk_q}} | (halo & ~side_ok);
    mask    = solid_q ? (empty_q & ~miss) : 6'd0;
    faces   = '0;
    for (int j = 0; j < 6; j++) begin
      faces = faces + 3'(mask[j]);
    end
    tri_add  = {faces, 1'b0};
    vtx_add  = {faces, 2'b00};
    vis      = (mask != 6'd0);
    tri_base = start_q ? '0 : tri_sum_q;
    vtx_base = start_q ? '0 : vtx_sum_q;
    vis_base = start_q ? '0 : vis_sum_q;
    hole_new = (start_q ? 1'b0 : hole_q) | (solid_q && (miss != 6'd0));
    tri_ext  = {1'b0, tri_base} + (TRI_W + 1)'(tri_add);
    vtx_ext  = {1'b0, vtx_base} + (VTX_W + 1)'(vtx_add);
    vis_ext  = {1'b0, vis_base} + (VIS_W + 1)'(1);
    tri_new  = tri_base;
    vtx_new  = vtx_base;
    vis_new  = vis_base;
    if (vis) begin
      tri_new = tri_ext[TRI_W] ? TRI_MAX : tri_ext[TRI_W-1:0];
      vtx_new = vtx_ext[VTX_W] ? VTX_MAX : vtx_ext[VTX_W-1:0];
      vis_new = vis_ext[VIS_W] ? VIS_MAX : vis_ext[VIS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tri_sum_q <= '0;
      vtx_sum_q <= '0;
      vis_sum_q <= '0;
      hole_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        m_valid_q <= 1'b1;
        if (!bad_q) begin
          tri_sum_q <= tri_new;
          vtx_sum_q <= vtx_new;
          vis_sum_q <= vis_new;
          hole_q    <= hole_new;
        end
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_user_q <= bad_q;
      if (bad_q) begin
        m_data_q <= '0;
      end else begin
        m_data_q <= {1'b0, hole_new, vis_new, vtx_new, tri_new, vtx_add, tri_add, vis, mask};
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

`ifndef SYNTHESIS
  // No item may enter while the clearing pass is still running.
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !s_axis_tready)
    else $error("item accepted during store clear");

  // A result only appears from the final state of a query.
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_DONE))
    else $error("result raised outside the done state");

  // Read data is captured only in the cycle after a read was issued.
  a_read_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> $past(ram_req.re))
    else $error("read data captured without a read");

  // The store is never read and written in the same cycle by the sequencer.
  a_port_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_req.re && ram_req.we))
    else $error("store read and written together");

  // A query outside the interior leaves every other result field zero.
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 64'd0))
    else $error("halo query result carries data");
`endif

endmodule
